// ----- rtl/hrce_pkg.sv -----
// Shared types and constants for the gamepad report change event block.
package hrce_pkg;

  localparam int unsigned REPORT_BYTES = 7;
  localparam int unsigned MAX_PAD_BYTES = 5;
  localparam int unsigned NUM_BUTTONS = 12;
  localparam int unsigned NUM_SLOTS = 3 + NUM_BUTTONS;
  localparam int unsigned SLOT_W = 4;

  localparam int unsigned SLOT_PAD = 0;
  localparam int unsigned SLOT_HAT = 1;
  localparam int unsigned SLOT_TT = 2;
  localparam int unsigned SLOT_BTN0 = 3;

  localparam logic [7:0] PAD_RST_VAL = 8'h0D;
  localparam logic [7:0] HAT_RST_VAL = 8'hDE;
  localparam logic [7:0] TT_FULL_SCALE = 8'hFF;

  typedef enum logic [2:0] {
    EV_PAD  = 3'd0,
    EV_HAT  = 3'd1,
    EV_TT   = 3'd2,
    EV_DOWN = 3'd3,
    EV_UP   = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]   mask;
    logic [3:0]             hat;
    logic [7:0]             tt;
    logic [NUM_BUTTONS-1:0] word;
    logic [23:0]            entry;
    logic [8:0]             alt_hi;
    logic [8:0]             alt_tt_old;
    logic [8:0]             alt_tt_new;
  } job_t;

  typedef struct packed {
    logic [7:0] event_value;
    logic [7:0] entry_turntable;
    logic [7:0] entry_buttons;
    logic [7:0] entry_extra_buttons;
    logic [8:0] alt_turntable;
    logic [6:0] alt_buttons;
    logic [1:0] alt_extra_buttons;
  } event_data_t;

endpackage

// ----- rtl/hid_report_change_events.sv -----
// Top level of the gamepad report change event block.
// The first event of a report passes the job register and then the result register.
// Throughput: one event per cycle while the output is not stalled; the input is held until
// the last event of a report is registered, and the next report transfers in that same cycle.
// A report that causes no event leaves nothing pending and does not hold the input.
// Reset: synchronous active-low rst_n restores the stored report and drops pending events.
module hid_report_change_events import hrce_pkg::*; #(
  parameter int unsigned PAD_BYTES = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // axis_x, axis_y, aux_a, aux_b, axis_rz, hat_and_buttons, turntable_byte
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // event_value, entry_turntable, entry_buttons, entry_extra_buttons,
  // alt_turntable, alt_buttons, alt_extra_buttons, zero fill
  output logic [55:0] out_tdata,
  // event_kind
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  logic        fire;
  logic        can_load;
  logic [7:0]  rpt [REPORT_BYTES];
  job_t        job;
  event_kind_t ev_kind;
  event_data_t ev_data;

  always_comb begin
    for (int i = 0; i < REPORT_BYTES; i++) begin
      rpt[i] = in_tdata[8*i +: 8];
    end
  end

  assign in_tready = can_load;
  assign fire      = in_tvalid && can_load;

  hrce_detect #(
    .PAD_BYTES (PAD_BYTES)
  ) u_detect (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .rpt   (rpt),
    .job   (job)
  );

  hrce_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .job_in    (job),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (ev_kind),
    .out_data  (ev_data),
    .out_last  (out_tlast)
  );

  assign out_tuser = ev_kind;
  assign out_tdata = {6'b000000, ev_data.alt_extra_buttons, ev_data.alt_buttons,
                      ev_data.alt_turntable, ev_data.entry_extra_buttons,
                      ev_data.entry_buttons, ev_data.entry_turntable, ev_data.event_value};

endmodule

// ----- rtl/hrce_detect.sv -----
// Change detection against the stored report and state update per report.
module hrce_detect import hrce_pkg::*; #(
  parameter int unsigned PAD_BYTES = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rpt [REPORT_BYTES],
  output job_t       job
);

  logic [7:0]             prev_pad_r [PAD_BYTES];
  logic [7:0]             prev_hat_r;
  logic [7:0]             prev_tt_r;
  logic [NUM_BUTTONS-1:0] prev_word_r;
  logic [23:0]            entry_r;
  logic [17:0]            alt_r;

  logic                   pad_chg;
  logic                   hat_chg;
  logic                   tt_chg;
  logic [3:0]             hat;
  logic [7:0]             tt;
  logic [NUM_BUTTONS-1:0] word;
  logic [NUM_BUTTONS-1:0] changes;
  logic [6:0]             abtn;
  logic [1:0]             aex;
  logic [8:0]             scaled;
  logic [23:0]            entry_nxt;
  logic [17:0]            alt_nxt;

  always_comb begin
    pad_chg = 1'b0;
    for (int i = 0; i < PAD_BYTES; i++) begin
      if (rpt[i] != prev_pad_r[i]) begin
        pad_chg = 1'b1;
      end
    end
    hat     = rpt[5][3:0];
    hat_chg = {4'b0000, hat} != prev_hat_r;
    tt      = rpt[6];
    tt_chg  = tt != prev_tt_r;
    word    = {rpt[6], rpt[5][7:4]};
    changes = word ^ prev_word_r;

    abtn = {rpt[2][7], rpt[3][0], rpt[3][5], rpt[3][3], rpt[3][6], rpt[3][2], rpt[3][7]};
    aex  = {rpt[2][3], rpt[2][0]};
    // x*511/255 truncated equals 2x plus one at full scale
    scaled = {tt, 1'b0} + {8'h00, tt == TT_FULL_SCALE};

    entry_nxt = pad_chg ? {rpt[2], rpt[1], rpt[3]} : entry_r;
    alt_nxt[17:9] = pad_chg ? {aex, abtn} : alt_r[17:9];
    alt_nxt[8:0]  = tt_chg ? scaled : alt_r[8:0];

    job.mask       = {changes, tt_chg, hat_chg, pad_chg};
    job.hat        = hat;
    job.tt         = tt;
    job.word       = word;
    job.entry      = entry_nxt;
    job.alt_hi     = alt_nxt[17:9];
    job.alt_tt_old = alt_r[8:0];
    job.alt_tt_new = alt_nxt[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAD_BYTES; i++) begin
        prev_pad_r[i] <= PAD_RST_VAL;
      end
      prev_hat_r  <= HAT_RST_VAL;
      prev_tt_r   <= '0;
      prev_word_r <= '0;
      entry_r     <= '0;
      alt_r       <= '0;
    end else if (fire) begin
      if (pad_chg) begin
        for (int i = 0; i < PAD_BYTES; i++) begin
          prev_pad_r[i] <= rpt[i];
        end
      end
      prev_hat_r  <= {4'b0000, hat};
      prev_tt_r   <= tt;
      prev_word_r <= word;
      entry_r     <= entry_nxt;
      alt_r       <= alt_nxt;
    end
  end

endmodule

// ----- rtl/hrce_serial.sv -----
// Job register and event serializer feeding the result register.
module hrce_serial import hrce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  job_t        job_in,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output event_kind_t out_kind,
  output event_data_t out_data,
  output logic        out_last
);

  job_t                 job_r;
  logic [NUM_SLOTS-1:0] pend_r;
  logic [NUM_SLOTS-1:0] pend_nxt;
  logic [NUM_SLOTS-1:0] low;
  logic [NUM_SLOTS-1:0] rest;
  logic [SLOT_W-1:0]    sel_idx;
  logic [SLOT_W-1:0]    btn_idx;
  logic                 emit;

  logic                 out_valid_r;
  event_kind_t          kind_r;
  event_kind_t          kind_nxt;
  event_data_t          data_r;
  event_data_t          data_nxt;
  logic                 last_r;

  always_comb begin
    low  = pend_r & (~pend_r + 1'b1);
    rest = pend_r & ~low;
    sel_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (low[i]) begin
        sel_idx = sel_idx | SLOT_W'(i);
      end
    end
    btn_idx = sel_idx - SLOT_W'(SLOT_BTN0);

    emit     = (|pend_r) && (!out_valid_r || out_ready);
    can_load = !(|pend_r) || (emit && !(|rest));

    if (load) begin
      pend_nxt = job_in.mask;
    end else if (emit) begin
      pend_nxt = rest;
    end else begin
      pend_nxt = pend_r;
    end

    data_nxt.entry_turntable     = job_r.entry[7:0];
    data_nxt.entry_buttons       = job_r.entry[15:8];
    data_nxt.entry_extra_buttons = job_r.entry[23:16];
    data_nxt.alt_buttons         = job_r.alt_hi[6:0];
    data_nxt.alt_extra_buttons   = job_r.alt_hi[8:7];
    data_nxt.alt_turntable       = job_r.alt_tt_new;
    data_nxt.event_value         = {4'b0000, sel_idx} - 8'(SLOT_BTN0 - 1);
    kind_nxt = job_r.word[btn_idx] ? EV_DOWN : EV_UP;
    case (sel_idx)
      SLOT_W'(SLOT_PAD): begin
        kind_nxt                = EV_PAD;
        data_nxt.event_value    = '0;
        data_nxt.alt_turntable  = job_r.alt_tt_old;
      end
      SLOT_W'(SLOT_HAT): begin
        kind_nxt                = EV_HAT;
        data_nxt.event_value    = {4'b0000, job_r.hat};
        data_nxt.alt_turntable  = job_r.alt_tt_old;
      end
      SLOT_W'(SLOT_TT): begin
        kind_nxt                = EV_TT;
        data_nxt.event_value    = job_r.tt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= kind_nxt;
      data_r <= data_nxt;
      last_r <= !(|rest);
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_data  = data_r;
  assign out_last  = last_r;

endmodule
